// ----- hdl/afx_pkg.sv -----
package afx_pkg;

   localparam int MAX_FEATURES = 16;
   localparam int IDX_W        = 4;
   localparam int CNT_W        = 5;
   localparam int VAL_W        = 16;
   localparam int PROD_W       = 2 * VAL_W;
   localparam int ACC_W        = 40;
   localparam int COEF_AW      = 2 * IDX_W;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_COEF    = 2'd0;
   localparam logic [1:0] REQ_OFFSET  = 2'd1;
   localparam logic [1:0] REQ_FEATURE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FEATURE_COUNT = 2'd0;
   localparam logic [1:0] CSR_USE_MATRIX    = 2'd1;
   localparam logic [1:0] CSR_USE_OFFSET    = 2'd2;

   // 2^12: lifts a Q7.8 word onto the 2^-20 accumulator scale
   localparam logic signed [VAL_W-1:0] SCALE_Q12 = 16'sd4096;

   typedef enum logic [1:0] {
      OP_MAC,
      OP_PASS,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [IDX_W-1:0]  col;
      logic              last;
   } tag_type;

endpackage

// ----- hdl/afx_store.sv -----
module afx_store (
   input  logic                               clock,
   input  logic                               coef_we,
   input  logic [afx_pkg::COEF_AW-1:0]        coef_waddr,
   input  logic                               offset_we,
   input  logic [afx_pkg::IDX_W-1:0]          offset_waddr,
   input  logic signed [afx_pkg::VAL_W-1:0]   wdata,
   input  logic [afx_pkg::COEF_AW-1:0]        coef_raddr,
   input  logic [afx_pkg::IDX_W-1:0]          offset_raddr,
   output logic signed [afx_pkg::VAL_W-1:0]   coef_rdata_ff,
   output logic signed [afx_pkg::VAL_W-1:0]   offset_rdata_ff
);
   import afx_pkg::*;

   logic signed [VAL_W-1:0] coef_mem [MAX_FEATURES*MAX_FEATURES];
   logic signed [VAL_W-1:0] offset_mem [MAX_FEATURES];

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= wdata;
      end
      coef_rdata_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (offset_we) begin
         offset_mem[offset_waddr] <= wdata;
      end
      offset_rdata_ff <= offset_mem[offset_raddr];
   end

endmodule

// ----- hdl/afx_mac.sv -----
module afx_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  afx_pkg::tag_type                  in_tag,
   input  logic signed [afx_pkg::VAL_W-1:0]  mul_a,
   input  logic signed [afx_pkg::VAL_W-1:0]  mul_b,
   input  logic signed [afx_pkg::ACC_W-1:0]  base,
   output afx_pkg::tag_type                  out_tag,
   output logic signed [afx_pkg::ACC_W-1:0]  sum
);
   import afx_pkg::*;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff;
   tag_type                  tag_ff;
   logic signed [ACC_W:0]    wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // saturating add of the registered product onto the base word
   always_comb begin
      wide = (ACC_W+1)'(base) + (ACC_W+1)'(prod_ff);
      if (wide[ACC_W] != wide[ACC_W-1]) begin
         sum = wide[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sum = wide[ACC_W-1:0];
      end
   end

   assign out_tag = tag_ff;

endmodule

// ----- hdl/affine_feature_transform.sv -----
// Affine feature transform y = x*B + c over frames of up to 16 Q7.8 features.
// Coefficient and offset transfers are taken only while idle; a feature holds the input
// while it visits every column with the matrix on, or its own column with it off; a closing
// feature holds it until its results have issued, each once the one before has left the MAC.
// Stalls on the result channel hold back the results.
// Synchronous active-high reset clears control, configuration and accumulators only.
module affine_feature_transform (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [afx_pkg::CNT_W-1:0]         csr_wdata,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // row_index, col_index, value
   input  logic [1:0]                        req_tuser,  // req_type
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // out_value, out_index, zero pad
   output logic                              rsp_tlast   // last_of_frame
);
   import afx_pkg::*;

   localparam logic signed [ACC_W:0] OUT_MAX  = (ACC_W+1)'(32767);
   localparam logic signed [ACC_W:0] OUT_MIN  = -(ACC_W+1)'(32768);
   localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W+1)'(2048);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         feature_count_ff;
   logic                     use_matrix_ff;
   logic                     use_offset_ff;
   logic [IDX_W-1:0]         row_ff;
   logic [IDX_W-1:0]         col_ff;
   logic signed [VAL_W-1:0]  feat_ff;
   logic                     close_ff;

   logic                     rsp_valid_ff;
   logic signed [VAL_W-1:0]  rsp_value_ff;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic                     rsp_last_ff;

   tag_type                  p1_ff;
   logic signed [VAL_W-1:0]  p1_feat_ff;
   logic signed [ACC_W-1:0]  acc_ff [MAX_FEATURES];

   // request fields
   logic [IDX_W-1:0]         req_row;
   logic [IDX_W-1:0]         req_col;
   logic signed [VAL_W-1:0]  req_value;
   logic                     req_xfer;

   logic [CNT_W-1:0]         eff_count;
   logic [IDX_W-1:0]         last_idx;
   logic                     emit_ok;
   tag_type                  iss;

   logic signed [VAL_W-1:0]  coef_rdata;
   logic signed [VAL_W-1:0]  offset_rdata;
   logic signed [VAL_W-1:0]  mul_a;
   logic signed [VAL_W-1:0]  mul_b;
   logic signed [ACC_W-1:0]  base;
   tag_type                  mac_tag;
   logic signed [ACC_W-1:0]  mac_sum;
   logic signed [VAL_W-1:0]  rounded;

   assign req_row   = req_tdata[IDX_W-1:0];
   assign req_col   = req_tdata[2*IDX_W-1:IDX_W];
   assign req_value = req_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer  = req_tvalid && req_tready;

   // clamp the count into 1..MAX_FEATURES
   always_comb begin
      if (feature_count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (feature_count_ff > CNT_W'(MAX_FEATURES)) begin
         eff_count = CNT_W'(MAX_FEATURES);
      end else begin
         eff_count = feature_count_ff;
      end
   end
   assign last_idx = IDX_W'(eff_count - CNT_W'(1));

   // issue an output column only once the result register will be free and
   // no earlier output column is still in the MAC pipeline
   assign emit_ok = (!rsp_valid_ff || rsp_tready)
                    && !(p1_ff.valid && p1_ff.op == OP_EMIT)
                    && !(mac_tag.valid && mac_tag.op == OP_EMIT);

   // issue slot of the shared MAC
   always_comb begin
      iss = '0;
      case (state_ff)
         ST_RUN: begin
            iss.valid = 1'b1;
            if (use_matrix_ff) begin
               iss.op  = OP_MAC;
               iss.col = col_ff;
            end else begin
               iss.op  = OP_PASS;
               iss.col = row_ff;
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               iss.valid = 1'b1;
               iss.op    = OP_EMIT;
               iss.col   = col_ff;
               iss.last  = (col_ff == last_idx);
            end
         end
         default: begin
            iss = '0;
         end
      endcase
   end

   afx_store u_store (
      .clock           (clock),
      .coef_we         (req_xfer && req_tuser == REQ_COEF),
      .coef_waddr      ({req_row, req_col}),
      .offset_we       (req_xfer && req_tuser == REQ_OFFSET),
      .offset_waddr    (req_col),
      .wdata           (req_value),
      .coef_raddr      ({row_ff, col_ff}),
      .offset_raddr    (col_ff),
      .coef_rdata_ff   (coef_rdata),
      .offset_rdata_ff (offset_rdata)
   );

   // first pipeline stage: aligns the tag with the store read data
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= '0;
      end else begin
         p1_ff <= iss;
      end
   end

   always_ff @(posedge clock) begin
      p1_feat_ff <= feat_ff;
   end

   // operand selection for the shared multiplier
   always_comb begin
      case (p1_ff.op)
         OP_MAC: begin
            mul_a = p1_feat_ff;
            mul_b = coef_rdata;
         end
         OP_PASS: begin
            mul_a = p1_feat_ff;
            mul_b = SCALE_Q12;
         end
         OP_EMIT: begin
            // with the offset off, keep the offset word out of the product
            mul_a = use_offset_ff ? offset_rdata : '0;
            mul_b = SCALE_Q12;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // pass-through overwrites its column, so start it from zero
   assign base = (mac_tag.op == OP_PASS) ? '0 : acc_ff[mac_tag.col];

   afx_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (p1_ff),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .base    (base),
      .out_tag (mac_tag),
      .sum     (mac_sum)
   );

   // write back the accumulators; drop them all once the frame's last
   // result has been formed
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_FEATURES; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (mac_tag.valid) begin
         if (mac_tag.op == OP_MAC || mac_tag.op == OP_PASS) begin
            acc_ff[mac_tag.col] <= mac_sum;
         end else if (mac_tag.op == OP_EMIT && mac_tag.last) begin
            for (int i = 0; i < MAX_FEATURES; i++) begin
               acc_ff[i] <= '0;
            end
         end
      end
   end

   // round half up to Q7.8 and saturate to 16 bits
   always_comb begin
      logic signed [ACC_W:0] r;
      logic signed [ACC_W:0] q;
      r = (ACC_W+1)'(mac_sum) + ROUND_HALF;
      q = r >>> 12;
      if (q > OUT_MAX) begin
         rounded = 16'sh7FFF;
      end else if (q < OUT_MIN) begin
         rounded = 16'sh8000;
      end else begin
         rounded = q[VAL_W-1:0];
      end
   end

   // sequencer, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         feature_count_ff <= CNT_W'(MAX_FEATURES);
         use_matrix_ff    <= 1'b1;
         use_offset_ff    <= 1'b1;
         col_ff           <= '0;
         close_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FEATURE_COUNT: feature_count_ff <= csr_wdata;
               CSR_USE_MATRIX:    use_matrix_ff    <= csr_wdata[0];
               CSR_USE_OFFSET:    use_offset_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               // features beyond the count cause nothing
               if (req_xfer && req_tuser == REQ_FEATURE
                   && {1'b0, req_row} < eff_count) begin
                  row_ff   <= req_row;
                  feat_ff  <= req_value;
                  close_ff <= (req_row == last_idx);
                  col_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (use_matrix_ff && col_ff != last_idx) begin
                  col_ff <= col_ff + IDX_W'(1);
               end else begin
                  col_ff   <= '0;
                  state_ff <= close_ff ? ST_EMIT : ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (emit_ok) begin
                  if (col_ff == last_idx) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     col_ff <= col_ff + IDX_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // load a result as it leaves the MAC, otherwise drain on transfer
         if (mac_tag.valid && mac_tag.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
            rsp_value_ff <= rounded;
            rsp_index_ff <= mac_tag.col;
            rsp_last_ff  <= mac_tag.last;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24-VAL_W-IDX_W){1'b0}}, rsp_index_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- bench/affine_feature_transform_tb.sv -----
module affine_feature_transform_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import afx_pkg::*;

   // req_type 3 has no meaning; the block must drop it without a result
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   localparam int     ITEM_TARGET   = 430;
   localparam int     IDLE_PERCENT  = 7;
   // quiet cycles let after the last result before a register write or the end
   localparam int     SETTLE_CYCLES = 64;
   // cycles in a row with no transfer on either channel before giving up
   localparam int     STALL_LIMIT   = 2000;
   localparam longint ACC_HI        = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_LO        = -ACC_HI - 1;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [IDX_W-1:0]        index;
      logic                    last;
   } frame_output_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [CNT_W-1:0]  csr_wdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata = '0;   // row_index, col_index, value
   logic [1:0]        req_tuser = '0;   // req_type
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;        // out_value, out_index, zero pad
   logic              rsp_tlast;        // last_of_frame

   // mirror of the block's registers and stores, kept in step with each transfer
   logic [CNT_W-1:0]        cfg_count  = 5'd16;
   logic                    cfg_matrix = 1'b1;
   logic                    cfg_offset = 1'b1;
   logic signed [VAL_W-1:0] coef_mem   [MAX_FEATURES*MAX_FEATURES];
   logic signed [VAL_W-1:0] offset_mem [MAX_FEATURES];
   longint                  column_acc [MAX_FEATURES];

   // which store entries hold a written word; a read of any other is never caused
   bit coef_loaded   [MAX_FEATURES*MAX_FEATURES];
   bit offset_loaded [MAX_FEATURES];

   frame_output_type outputs_due[$];
   int            error_count  = 0;
   int            items_sent   = 0;
   int            idle_pct     = IDLE_PERCENT;
   int            quiet_cycles = 0;
   bit            timed_out    = 1'b0;

   affine_feature_transform u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at random; a zero idle_pct holds tready high.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   // Count cycles with no transfer at all; the main process watches this.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Feature count as the block uses it: 0 acts as 1, above 16 acts as 16.
   function automatic int active_count();
      if (cfg_count == 0) return 1;
      if (cfg_count > MAX_FEATURES) return MAX_FEATURES;
      return int'(cfg_count);
   endfunction

   // Saturate to the signed accumulator width.
   function automatic longint clamp_acc(longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
   endfunction

   // Apply one accepted request to the mirrored state; queue the frame's
   // outputs when this element closes the frame.
   task automatic predict_transform(logic [1:0] kind, logic [IDX_W-1:0] row,
                                    logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] value);
      int               n;
      longint           sum;
      longint           y;
      frame_output_type out;
      case (kind)
         REQ_COEF: begin
            coef_mem[row*MAX_FEATURES + col] = value;
         end
         REQ_OFFSET: begin
            offset_mem[col] = value;
         end
         REQ_FEATURE: begin
            n = active_count();
            if (row < n) begin
               // matrix on: one row of B into every column; off: copy into the feature's own column
               if (cfg_matrix) begin
                  for (int j = 0; j < n; j++) begin
                     column_acc[j] = clamp_acc(column_acc[j] + longint'(value)
                                     * longint'(coef_mem[row*MAX_FEATURES + j]));
                  end
               end else begin
                  column_acc[row] = clamp_acc(longint'(value) * 4096);
               end
               if (row == n - 1) begin
                  for (int j = 0; j < n; j++) begin
                     sum = column_acc[j];
                     if (cfg_offset) sum = clamp_acc(sum + longint'(offset_mem[j]) * 4096);
                     // round half up, then back to Q7.8 and saturate to 16 bits
                     sum = clamp_acc(sum + 2048);
                     y = sum >>> 12;
                     if (y > 32767) y = 32767;
                     if (y < -32768) y = -32768;
                     out.value = y[15:0];
                     out.index = 4'(j);
                     out.last  = (j == n - 1);
                     outputs_due.push_back(out);
                  end
                  foreach (column_acc[j]) column_acc[j] = 0;
               end
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Result checking: compare each result transfer with the oldest output due
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_outputs
      frame_output_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outputs_due.size() == 0) begin
            error_count++;
            $display("%0t: result with none due: expected nothing, actual value %0d index %0d last %0b",
                     $time, $signed(rsp_tdata[15:0]), rsp_tdata[19:16], rsp_tlast);
         end else begin
            due = outputs_due.pop_front();
            if (rsp_tdata[15:0] !== due.value) begin
               error_count++;
               $display("%0t: out_value expected %0d actual %0d (index %0d)",
                        $time, due.value, $signed(rsp_tdata[15:0]), due.index);
            end
            if (rsp_tdata[19:16] !== due.index) begin
               error_count++;
               $display("%0t: out_index expected %0d actual %0d",
                        $time, due.index, rsp_tdata[19:16]);
            end
            if (rsp_tlast !== due.last) begin
               error_count++;
               $display("%0t: last_of_frame expected %0b actual %0b (index %0d)",
                        $time, due.last, rsp_tlast, due.index);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Mostly small words, a quarter across the full 16-bit range.
   function automatic logic signed [VAL_W-1:0] rand_sample();
      if ($urandom_range(3) == 0) return 16'($urandom_range(65535));
      return 16'(int'($urandom_range(1023)) - 512);
   endfunction

   // Send one request transfer. Entered and left at a falling edge; valid is
   // held high across back-to-back transfers; this task drops it only for an idle gap.
   task automatic send_request(logic [1:0] kind, logic [IDX_W-1:0] row,
                               logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] value);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {value, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_transform(kind, row, col, value);
      if (kind == REQ_COEF) coef_loaded[row*MAX_FEATURES + col] = 1'b1;
      if (kind == REQ_OFFSET) offset_loaded[col] = 1'b1;
      items_sent++;
      @(negedge clock);
   endtask

   // Send a feature element, first loading any coefficient or offset word that
   // this element would read and that has never been written.
   task automatic send_feature(logic [IDX_W-1:0] row, logic signed [VAL_W-1:0] value);
      int n;
      n = active_count();
      if (row < n) begin
         if (cfg_matrix) begin
            for (int j = 0; j < n; j++) begin
               if (!coef_loaded[row*MAX_FEATURES + j])
                  send_request(REQ_COEF, row, 4'(j), rand_sample());
            end
         end
         if (cfg_offset && row == n - 1) begin
            for (int j = 0; j < n; j++) begin
               if (!offset_loaded[j])
                  send_request(REQ_OFFSET, 4'($urandom_range(15)), 4'(j), rand_sample());
            end
         end
      end
      send_request(REQ_FEATURE, row, 4'($urandom_range(15)), value);
   endtask

   // Drop valid, wait for every output due, then let the block fall quiet.
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      wait (outputs_due.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register; only called with the block idle.
   task automatic write_reg(logic [1:0] index, logic [CNT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_FEATURE_COUNT: cfg_count  = data;
         CSR_USE_MATRIX:    cfg_matrix = data[0];
         CSR_USE_OFFSET:    cfg_offset = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // One-feature frames at the value extremes: the rounding and the 16-bit
   // saturation at both ends, with the offset added.
   task automatic test_value_extremes();
      write_reg(CSR_FEATURE_COUNT, 5'd1);
      write_reg(CSR_USE_MATRIX, 5'd1);
      write_reg(CSR_USE_OFFSET, 5'd1);
      send_request(REQ_COEF, 4'd0, 4'd0, 16'sh7FFF);
      send_request(REQ_OFFSET, 4'd15, 4'd0, 16'sh8000);
      send_feature(4'd0, 16'sh7FFF);
      send_feature(4'd0, 16'sh8000);
      send_request(REQ_COEF, 4'd0, 4'd0, 16'sh8000);
      send_feature(4'd0, 16'sh8000);
      send_feature(4'd0, 16'sh0000);
   endtask

   // Matrix off: features copy through; a repeated index overwrites its column,
   // an early close leaves missing columns at zero.
   task automatic test_pass_through();
      drain_outputs();
      write_reg(CSR_FEATURE_COUNT, 5'd4);
      write_reg(CSR_USE_MATRIX, 5'd0);
      write_reg(CSR_USE_OFFSET, 5'd0);
      send_feature(4'd0, 16'sh7FFF);
      send_feature(4'd1, 16'sh8000);
      send_feature(4'd1, 16'sh0100);
      send_feature(4'd3, 16'shFFFF);
      drain_outputs();
      write_reg(CSR_USE_OFFSET, 5'd1);
      send_request(REQ_OFFSET, 4'd0, 4'd0, 16'sh7FFF);
      send_feature(4'd2, 16'sh0080);
      send_feature(4'd0, 16'sh7FFF);
      send_feature(4'd3, 16'sh8001);
   endtask

   // Requests the block must drop, and feature counts outside 1..16.
   task automatic test_ignored_requests();
      drain_outputs();
      write_reg(CSR_FEATURE_COUNT, 5'd2);
      write_reg(CSR_USE_MATRIX, 5'd1);
      send_request(REQ_UNKNOWN, 4'hF, 4'hF, 16'shFFFF);
      send_feature(4'd15, 16'sh1234);
      drain_outputs();
      // a count of zero behaves as one: row 0 closes, row 1 is dropped
      write_reg(CSR_FEATURE_COUNT, 5'd0);
      send_feature(4'd1, 16'sh0200);
      send_feature(4'd0, 16'sh0300);
      drain_outputs();
      // a count above the maximum behaves as sixteen
      write_reg(CSR_FEATURE_COUNT, 5'd31);
      write_reg(CSR_USE_MATRIX, 5'd0);
      write_reg(CSR_USE_OFFSET, 5'd0);
      send_feature(4'd15, 16'sh0400);
   endtask

   // The matrix switch changes inside an open frame; each element follows the
   // setting at its own arrival, the offset switch is taken at the close.
   task automatic test_mode_change_in_frame();
      drain_outputs();
      write_reg(CSR_FEATURE_COUNT, 5'd2);
      write_reg(CSR_USE_MATRIX, 5'd1);
      write_reg(CSR_USE_OFFSET, 5'd0);
      send_feature(4'd0, 16'sh0180);
      drain_outputs();
      write_reg(CSR_USE_MATRIX, 5'd0);
      write_reg(CSR_USE_OFFSET, 5'd1);
      send_feature(4'd1, 16'shFE00);
   endtask

   // Mostly well-formed frames with random content under random settings,
   // with stray writes, unknown requests, stray and missing elements mixed in.
   task automatic test_random_frames();
      int phase;
      int roll;
      int frames;
      int n;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain_outputs();
         roll = $urandom_range(9);
         if (roll < 2) write_reg(CSR_FEATURE_COUNT, 5'd1);
         else if (roll < 4) write_reg(CSR_FEATURE_COUNT, 5'd16);
         else if (roll == 4) write_reg(CSR_FEATURE_COUNT, 5'($urandom_range(31)));
         else write_reg(CSR_FEATURE_COUNT, 5'($urandom_range(2, 8)));
         write_reg(CSR_USE_MATRIX, {4'($urandom_range(15)), 1'($urandom_range(3) != 0)});
         write_reg(CSR_USE_OFFSET, {4'($urandom_range(15)), 1'($urandom_range(1))});
         n = active_count();
         // one long stretch with no idling on either channel
         idle_pct = (phase == 2) ? 0 : IDLE_PERCENT;
         frames = (phase == 2) ? 6 : (n >= 12) ? 1 : $urandom_range(1, 4);
         repeat (frames) begin
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(99) < 10) begin
                  case ($urandom_range(3))
                     0: send_request(REQ_COEF, 4'($urandom_range(15)), 4'($urandom_range(15)),
                                     rand_sample());
                     1: send_request(REQ_OFFSET, 4'($urandom_range(15)), 4'($urandom_range(15)),
                                     rand_sample());
                     2: send_request(REQ_UNKNOWN, 4'($urandom_range(15)), 4'($urandom_range(15)),
                                     16'($urandom_range(65535)));
                     default: send_feature(4'($urandom_range(15)), rand_sample());
                  endcase
               end
               // now and then skip an element to leave a hole in the frame
               if ($urandom_range(99) >= 4 || k == n - 1) send_feature(4'(k), rand_sample());
            end
         end
         phase++;
      end
      idle_pct = IDLE_PERCENT;
   endtask

   // ------------------------------------------------------------------
   // Sequence: reset, directed tests, random frames, then wait for the tail
   // ------------------------------------------------------------------
   initial begin
      foreach (column_acc[j]) column_acc[j] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      fork
         begin
            test_value_extremes();
            test_pass_through();
            test_ignored_requests();
            test_mode_change_in_frame();
            test_random_frames();
            drain_outputs();
         end
         begin
            wait (quiet_cycles >= STALL_LIMIT);
            timed_out = 1'b1;
         end
      join_any
      if (!timed_out && error_count == 0 && outputs_due.size() == 0) begin
         $display("PASS affine_feature_transform");
      end else begin
         $display("FAIL affine_feature_transform");
      end
      $finish;
   end

endmodule
